### sv/gaussian_pdf_eval_macros.svh
// Assertion helpers shared by gpe_queue and gpe_back.
// Clock is clock, reset is reset (synchronous, active high).
`ifndef GAUSSIAN_PDF_EVAL_MACROS_SVH
`define GAUSSIAN_PDF_EVAL_MACROS_SVH

// Same-cycle implication.
`define GPE_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gaussian_pdf_eval: assertion failed");

// Next-cycle implication.
`define GPE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gaussian_pdf_eval: assertion failed");

`endif

### sv/gpe_pkg.sv
`default_nettype none

package gpe_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int ITV_W     = 32;
   localparam int NORM_W    = 24;
   localparam int DENS_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // exponent: k beyond this shifts the product out entirely
   localparam int K_MAX = 24;
   localparam int K_W   = 5;
   localparam int F_W   = 16;

   // mantissa Q1.30 unsigned, value up to 1.0 inclusive
   localparam int M_W = 31;
   localparam int C_W = 30;

   localparam int unsigned LOG2E_Q16  = 94548;
   localparam int unsigned LN2_Q16    = 45426;
   localparam longint unsigned ONE_Q30    = 64'h0000_0000_4000_0000;
   localparam longint unsigned HALF_Q30   = 64'h0000_0000_2000_0000;
   localparam longint unsigned HALF_Q32   = 64'h0000_0000_8000_0000;
   localparam int SHIFT_BASE = 29;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEAN = 2'd0,
      CSR_ITV  = 2'd1,
      CSR_NORM = 2'd2
   } gpe_csr_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean;
      logic [ITV_W-1:0]           itv;
      logic [NORM_W-1:0]          norm;
   } gpe_cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic           zero;
      logic [K_W-1:0] k;
      logic [F_W-1:0] f;
   } gpe_item_type;

   function automatic longint unsigned isqrt64(input longint unsigned v_arg);
      longint unsigned v;
      longint unsigned res;
      longint unsigned bit_w;
      v     = v_arg;
      res   = 0;
      bit_w = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bit_w) begin
            v   = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // 2^-(1/2^(idx+1)) in Q0.30, elaboration time only
   function automatic longint unsigned root_const(input int idx);
      longint unsigned c;
      c = isqrt64(64'h0800_0000_0000_0000);
      for (int j = 0; j < idx; j++) begin
         c = isqrt64(c << 30);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/gpe_req_if.sv
`default_nettype none

interface gpe_req_if;
   import gpe_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### sv/gpe_rsp_if.sv
`default_nettype none

interface gpe_rsp_if;
   import gpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [DENS_W-1:0] density;

   modport source (output valid, output density, input ready);
   modport sink   (input valid, input density, output ready);
endinterface

`default_nettype wire

### sv/gpe_front.sv
`default_nettype none

module gpe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  gpe_pkg::gpe_cfg_type cfg,
   gpe_req_if.sink              req,
   input  logic                 full_i,
   output logic                 push_o,
   output gpe_pkg::gpe_item_type item_o
);
   import gpe_pkg::*;

   logic en;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0] ad_ff, ad_in;
   logic [31:0] sq_ff, sq_in;
   logic [20:0] t_ff, t_in;
   logic        big_ff, big_in;
   gpe_item_type item_ff, item_in;

   logic [16:0] diff;
   logic [16:0] ndiff;
   logic [63:0] prod_t;
   logic [37:0] prod_u;
   logic [5:0]  k_full;

   // whole front stalls only when its last item cannot enter the queue;
   // nothing is taken while reset is held
   assign en        = !(v4_ff && full_i);
   assign req.ready = en && !reset;
   assign push_o    = v4_ff && !full_i;
   assign item_o    = item_ff;

   always_comb begin
      diff  = {req.sample[SAMPLE_W-1], req.sample} - {cfg.mean[SAMPLE_W-1], cfg.mean};
      ndiff = -diff;
      ad_in = diff[16] ? ndiff[15:0] : diff[15:0];
   end

   assign sq_in = 32'(ad_ff) * 32'(ad_ff);

   // argument t in units of 2^-16; anything from 32.0 up yields zero
   always_comb begin
      prod_t = 64'(sq_ff) * 64'(cfg.itv);
      t_in   = prod_t[36:16];
      big_in = |prod_t[63:37];
   end

   always_comb begin
      prod_u       = 38'(t_ff) * 38'(LOG2E_Q16);
      k_full       = prod_u[37:32];
      item_in.zero = big_ff || (k_full > 6'(K_MAX));
      item_in.k    = k_full[K_W-1:0];
      item_in.f    = prod_u[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff   <= ad_in;
         sq_ff   <= sq_in;
         t_ff    <= t_in;
         big_ff  <= big_in;
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### sv/gpe_queue.sv
`default_nettype none
`include "gaussian_pdf_eval_macros.svh"

module gpe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  gpe_pkg::gpe_item_type item_i,
   output logic                  full_o,
   input  logic                  pop_i,
   output logic                  empty_o,
   output gpe_pkg::gpe_item_type item_o
);
   import gpe_pkg::*;

   gpe_item_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full_o  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty_o = (count_ff == '0);
   assign item_o  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push_i ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop_i ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + CNT_W'(push_i) - CNT_W'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ff] <= item_i;
      end
   end

   `GPE_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `GPE_ASSERT_IMPL(a_no_push_full, full_o, !push_i)
   `GPE_ASSERT_NEXT(a_pop_count, pop_i && !push_i, count_ff == $past(count_ff) - 1'b1)

endmodule

`default_nettype wire

### sv/gpe_back.sv
`default_nettype none
`include "gaussian_pdf_eval_macros.svh"

module gpe_back #(
   parameter int EXP_TABLE_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gpe_pkg::gpe_cfg_type  cfg,
   input  logic                  empty_i,
   input  gpe_pkg::gpe_item_type item_i,
   output logic                  pop_o,
   gpe_rsp_if.source             rsp
);
   import gpe_pkg::*;

   localparam int REM_W  = F_W - EXP_TABLE_BITS;
   localparam int LIN_W  = REM_W + 16;
   localparam int PL_W   = M_W + LIN_W;
   localparam int CORR_W = PL_W - 31;
   localparam int N_W    = M_W + NORM_W;
   localparam int MC_W   = M_W + C_W;

   logic en;

   // entry stage: linear coefficient r*ln2
   logic             b0v_ff;
   gpe_item_type     b0i_ff;
   logic [LIN_W-1:0] b0l_ff, b0l_in;

   // table stages
   logic             sv_w [EXP_TABLE_BITS];
   gpe_item_type     si_w [EXP_TABLE_BITS];
   logic [LIN_W-1:0] sl_w [EXP_TABLE_BITS];
   logic [M_W-1:0]   sm_w [EXP_TABLE_BITS];
   logic             tv_ff [EXP_TABLE_BITS];
   gpe_item_type     ti_ff [EXP_TABLE_BITS];
   logic [LIN_W-1:0] tl_ff [EXP_TABLE_BITS];
   logic [M_W-1:0]   tm_ff [EXP_TABLE_BITS];
   logic [M_W-1:0]   tm_in [EXP_TABLE_BITS];

   // linear step
   logic              l1v_ff;
   gpe_item_type      l1i_ff;
   logic [M_W-1:0]    l1m_ff;
   logic [CORR_W-1:0] l1c_ff, l1c_in;
   logic [PL_W-1:0]   lin_prod;
   logic [PL_W:0]     lin_sum;
   logic              l2v_ff;
   gpe_item_type      l2i_ff;
   logic [M_W-1:0]    l2m_ff, l2m_in;

   // normalization and final shift
   logic              nv_ff;
   gpe_item_type      ni_ff;
   logic [N_W-1:0]    np_ff, np_in;
   logic [5:0]        shamt;
   logic [N_W-1:0]    shifted;
   logic [26:0]       rnd_sum;
   logic [25:0]       rnd_res;
   logic              ov_ff;
   logic [DENS_W-1:0] dens_ff, dens_in;

   assign en          = !ov_ff || rsp.ready;
   assign pop_o       = en && !empty_i;
   assign rsp.valid   = ov_ff;
   assign rsp.density = dens_ff;

   assign b0l_in = LIN_W'(item_i.f[REM_W-1:0]) * LIN_W'(LN2_Q16);

   always_ff @(posedge clock) begin
      if (reset) begin
         b0v_ff <= 1'b0;
      end else if (en) begin
         b0v_ff <= !empty_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0i_ff <= item_i;
         b0l_ff <= b0l_in;
      end
   end

   for (genvar i = 0; i < EXP_TABLE_BITS; i++) begin : g_tab
      localparam logic [C_W-1:0] CI = C_W'(root_const(i));
      logic [MC_W-1:0] prod;
      logic [MC_W-1:0] rnd;

      if (i == 0) begin : g_first
         assign sv_w[i] = b0v_ff;
         assign si_w[i] = b0i_ff;
         assign sl_w[i] = b0l_ff;
         assign sm_w[i] = M_W'(ONE_Q30);
      end else begin : g_next
         assign sv_w[i] = tv_ff[i-1];
         assign si_w[i] = ti_ff[i-1];
         assign sl_w[i] = tl_ff[i-1];
         assign sm_w[i] = tm_ff[i-1];
      end

      // multiply by the root constant when this fraction bit is set
      always_comb begin
         prod     = MC_W'(sm_w[i]) * MC_W'(CI);
         rnd      = prod + MC_W'(HALF_Q30);
         tm_in[i] = si_w[i].f[F_W-1-i] ? rnd[M_W+29:30] : sm_w[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tv_ff[i] <= 1'b0;
         end else if (en) begin
            tv_ff[i] <= sv_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ti_ff[i] <= si_w[i];
            tl_ff[i] <= sl_w[i];
            tm_ff[i] <= tm_in[i];
         end
      end
   end

   always_comb begin
      lin_prod = PL_W'(tm_ff[EXP_TABLE_BITS-1]) * PL_W'(tl_ff[EXP_TABLE_BITS-1]);
      lin_sum  = {1'b0, lin_prod} + (PL_W+1)'(HALF_Q32);
      l1c_in   = lin_sum[PL_W:32];
   end

   assign l2m_in = l1m_ff - M_W'(l1c_ff);
   assign np_in  = N_W'(l2m_ff) * N_W'(cfg.norm);

   // round half up at bit s-1, s = 30 + k
   always_comb begin
      shamt   = 6'(SHIFT_BASE) + 6'(ni_ff.k);
      shifted = np_ff >> shamt;
      rnd_sum = 27'(shifted[25:0]) + 27'd1;
      rnd_res = rnd_sum[26:1];
      if (ni_ff.zero) begin
         dens_in = '0;
      end else if (rnd_res > 26'(24'hFF_FFFF)) begin
         dens_in = 24'hFF_FFFF;
      end else begin
         dens_in = rnd_res[DENS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1v_ff <= 1'b0;
         l2v_ff <= 1'b0;
         nv_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else if (en) begin
         l1v_ff <= tv_ff[EXP_TABLE_BITS-1];
         l2v_ff <= l1v_ff;
         nv_ff  <= l2v_ff;
         ov_ff  <= nv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1i_ff  <= ti_ff[EXP_TABLE_BITS-1];
         l1m_ff  <= tm_ff[EXP_TABLE_BITS-1];
         l1c_ff  <= l1c_in;
         l2i_ff  <= l1i_ff;
         l2m_ff  <= l2m_in;
         ni_ff   <= l2i_ff;
         np_ff   <= np_in;
         dens_ff <= dens_in;
      end
   end

   `GPE_ASSERT_IMPL(a_mant_bound, tv_ff[EXP_TABLE_BITS-1], tm_ff[EXP_TABLE_BITS-1] <= M_W'(ONE_Q30))
   `GPE_ASSERT_IMPL(a_corr_bound, l1v_ff, M_W'(l1c_ff) <= l1m_ff)
   `GPE_ASSERT_NEXT(a_out_load, nv_ff && en, ov_ff)

endmodule

`default_nettype wire

### sv/gaussian_pdf_eval.sv
// Channel  Dir  Handshake             Payload
// req_ch   in   valid/ready           sample   Q8.8 signed, 16 bits
// rsp_ch   out  valid/ready           density  Q8.16 unsigned, 24 bits, saturating
// csr_*    in   write enable only     index 0 mean, 1 inv_twice_variance, 2 norm_factor
//
// One item per cycle sustained while rsp_ch.ready stays high; every multiply
// sits in its own stage. Stages: 4 front, the queue, EXP_TABLE_BITS + 5 back.
// Reset (synchronous) empties the pipes and queue and loads the default registers.
// A low rsp_ch.ready holds the back end; the 4-entry queue then fills and
// req_ch.ready drops once the front end's last stage cannot push.
`default_nettype none

module gaussian_pdf_eval #(
   parameter int EXP_TABLE_BITS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   gpe_req_if.sink                         req_ch,
   gpe_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [gpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gpe_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import gpe_pkg::*;

   // configuration registers
   gpe_cfg_type cfg_ff, cfg_in;

   // front to queue
   logic         push;
   logic         full;
   gpe_item_type front_item;

   // queue to back
   logic         pop;
   logic         empty;
   gpe_item_type queue_item;

   // writes to unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MEAN: cfg_in.mean = csr_wdata[SAMPLE_W-1:0];
            CSR_ITV:  cfg_in.itv  = csr_wdata[ITV_W-1:0];
            CSR_NORM: cfg_in.norm = csr_wdata[NORM_W-1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean <= '0;
         cfg_ff.itv  <= 32'd32768;   // 0.5
         cfg_ff.norm <= 24'd26145;   // about 0.39894
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: difference, square, scale, base-2 split, zero classification
   gpe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_ch),
      .full_i (full),
      .push_o (push),
      .item_o (front_item)
   );

   gpe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .item_i  (front_item),
      .full_o  (full),
      .pop_i   (pop),
      .empty_o (empty),
      .item_o  (queue_item)
   );

   // back: table exponential, linear step, normalization, shift and clamp
   gpe_back #(
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .empty_i (empty),
      .item_i  (queue_item),
      .pop_o   (pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire
